// ===== sv/icb_pkg.sv =====
// types and constants shared by the indexed char buffer modules
`timescale 1ns / 1ps

package icb_pkg;

  // fixed field widths
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned STAT_W  = 2;

  // bytes per first-level group of the read gather
  localparam int unsigned GRP_SIZE = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_SET    = 3'd2,
    FN_GET    = 3'd3,
    FN_POP    = 3'd4,
    FN_REMOVE = 3'd5,
    FN_CLEAR  = 3'd6,
    FN_NOP    = 3'd7
  } icb_func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } icb_status_e;

  // per-cell edit broadcast along the row
  typedef enum logic [1:0] {
    COP_HOLD   = 2'd0,
    COP_WRITE  = 2'd1,
    COP_INSERT = 2'd2,
    COP_REMOVE = 2'd3
  } icb_cop_e;

  typedef struct packed {
    icb_func_e         func;
    logic [CHAR_W-1:0] char_in;
    logic [INDEX_W-1:0] index;
  } icb_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0]  length;
    icb_status_e       status;
  } icb_rsp_t;

  typedef struct packed {
    icb_cop_e          op;
    logic [CHAR_W-1:0] din;
  } icb_cell_ctl_t;

  // position flags of one cell relative to the edit target
  typedef struct packed {
    logic at;    // cell is the target
    logic past;  // cell lies above the target
  } icb_sel_t;

endpackage

// ===== sv/indexed_char_buffer.sv =====
// top level of the indexed char buffer: decode, count, cell row and result path
`timescale 1ns / 1ps

// an accepted word is registered in v1_q and then in done_q, which drives the result strobe
// throughput: one word per cycle, busy is never raised and edits finish in the row at once
// the read gather is a two-level and-or, registered between the levels
// reset clears the count and the result strobe; cell contents are undefined until written
// the receiver cannot stall: every result is on rsp_o for exactly the cycle done_o is high

module indexed_char_buffer #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  icb_pkg::icb_req_t req_i,
  output logic              done_o,
  output icb_pkg::icb_rsp_t rsp_o
);

  // count holds 0..CAPACITY; compares run at the wider of count and index
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > icb_pkg::INDEX_W) ? CW : icb_pkg::INDEX_W;

  // handshake
  logic accept;

  // count state
  logic [CW-1:0] count_d, count_q;

  // decode results
  icb_pkg::icb_status_e   status;
  icb_pkg::icb_cell_ctl_t cell_ctl;
  logic [CMPW-1:0]        cnt_ext, idx_ext, wr_tgt, rd_tgt;
  logic                   rd_en;
  logic                   full, empty;

  // row wiring
  icb_pkg::icb_sel_t [CAPACITY-1:0]           cell_sel;
  logic [CAPACITY-1:0][icb_pkg::CHAR_W-1:0]   cell_q;
  logic [CAPACITY-1:0]                        rd_sel;
  logic [icb_pkg::CHAR_W-1:0]                 rd_byte;

  // first result stage, lines up with the gather group registers
  logic                         v1_q;
  logic [icb_pkg::LEN_W-1:0]    len1_d, len1_q;
  icb_pkg::icb_status_e         st1_q;

  // output register
  logic              done_q;
  icb_pkg::icb_rsp_t rsp_q;

  // every edit lands in the row in the cycle it is accepted, so no stall is needed
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign cnt_ext = CMPW'(count_q);
  assign idx_ext = CMPW'(req_i.index);
  assign full    = (count_q == CW'(CAPACITY));
  assign empty   = (count_q == '0);

  // operation decode: status, new count, row edit and read target
  always_comb begin
    status       = icb_pkg::ST_OK;
    count_d      = count_q;
    cell_ctl.op  = icb_pkg::COP_HOLD;
    cell_ctl.din = req_i.char_in;
    wr_tgt       = idx_ext;
    rd_tgt       = idx_ext;
    rd_en        = 1'b0;
    unique case (req_i.func)
      icb_pkg::FN_APPEND: begin
        if (full) begin
          status = icb_pkg::ST_FULL;
        end else begin
          cell_ctl.op = icb_pkg::COP_WRITE;
          wr_tgt      = cnt_ext;
          count_d     = count_q + CW'(1);
        end
      end
      icb_pkg::FN_INSERT: begin
        // full wins over a bad index
        if (full) begin
          status = icb_pkg::ST_FULL;
        end else if (idx_ext > cnt_ext) begin
          status = icb_pkg::ST_RANGE;
        end else begin
          cell_ctl.op = icb_pkg::COP_INSERT;
          count_d     = count_q + CW'(1);
        end
      end
      icb_pkg::FN_SET: begin
        if (idx_ext >= cnt_ext) begin
          status = icb_pkg::ST_RANGE;
        end else begin
          cell_ctl.op = icb_pkg::COP_WRITE;
        end
      end
      icb_pkg::FN_GET: begin
        if (idx_ext >= cnt_ext) begin
          status = icb_pkg::ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      icb_pkg::FN_POP: begin
        if (empty) begin
          status = icb_pkg::ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_tgt  = cnt_ext - CMPW'(1);
          count_d = count_q - CW'(1);
        end
      end
      icb_pkg::FN_REMOVE: begin
        // old byte is gathered before the row closes the gap
        if (idx_ext >= cnt_ext) begin
          status = icb_pkg::ST_RANGE;
        end else begin
          rd_en       = 1'b1;
          cell_ctl.op = icb_pkg::COP_REMOVE;
          count_d     = count_q - CW'(1);
        end
      end
      icb_pkg::FN_CLEAR: begin
        count_d = '0;
      end
      icb_pkg::FN_NOP: begin
        count_d = count_q;
      end
    endcase
    // nothing moves unless a word is taken
    if (!accept) begin
      cell_ctl.op = icb_pkg::COP_HOLD;
      rd_en       = 1'b0;
      count_d     = count_q;
    end
  end

  assign len1_d = icb_pkg::LEN_W'(count_d);

  // row of cells; each cell sees its neighbors and its own position flags
  for (genvar i = 0; i < CAPACITY; i++) begin : g_row
    logic [icb_pkg::CHAR_W-1:0] left_byte, right_byte;

    assign cell_sel[i].at   = (wr_tgt == CMPW'(i));
    assign cell_sel[i].past = (CMPW'(i) > wr_tgt);
    assign rd_sel[i]        = rd_en & (rd_tgt == CMPW'(i));

    // ends of the row: the bottom never takes from the left, the top takes a filler
    if (i == 0) begin : g_bot
      assign left_byte = '0;
    end else begin : g_mid_l
      assign left_byte = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign right_byte = '0;
    end else begin : g_mid_r
      assign right_byte = cell_q[i+1];
    end

    icb_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .sel_i   (cell_sel[i]),
      .left_i  (left_byte),
      .right_i (right_byte),
      .q_o     (cell_q[i])
    );
  end

  // read gather: old contents captured on the accept edge
  icb_gather #(
    .CAPACITY (CAPACITY)
  ) u_gather (
    .clk_i   (clk_i),
    .cells_i (cell_q),
    .sel_i   (rd_sel),
    .byte_o  (rd_byte)
  );

  // count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      done_q <= v1_q;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    len1_q         <= len1_d;
    st1_q          <= status;
    rsp_q.char_out <= rd_byte;
    rsp_q.length   <= len1_q;
    rsp_q.status   <= st1_q;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef NO_ASSERTIONS
  // each accepted word gives a result strobe once it has passed v1_q and done_q
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("accepted word produced no result strobe");

  // no strobe without an earlier accepted word
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result strobe without an accepted word");

  // count stays within the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("count above capacity");

  // count moves only on an accepted word
  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(accept))
    else $error("count changed with no word accepted");

  // an error result carries a zero byte
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != icb_pkg::ST_OK) |-> (rsp_o.char_out == '0))
    else $error("error result with nonzero byte");
`endif

endmodule

// ===== sv/icb_cell.sv =====
// one byte cell of the storage row
`timescale 1ns / 1ps

module icb_cell (
  input  logic                             clk_i,
  input  icb_pkg::icb_cell_ctl_t           ctl_i,
  input  icb_pkg::icb_sel_t                sel_i,
  input  logic [icb_pkg::CHAR_W-1:0]       left_i,
  input  logic [icb_pkg::CHAR_W-1:0]       right_i,
  output logic [icb_pkg::CHAR_W-1:0]       q_o
);

  logic [icb_pkg::CHAR_W-1:0] byte_d, byte_q;

  always_comb begin
    byte_d = byte_q;
    case (ctl_i.op)
      icb_pkg::COP_WRITE: begin
        if (sel_i.at) byte_d = ctl_i.din;
      end
      icb_pkg::COP_INSERT: begin
        // bytes above the slot move up one place
        if (sel_i.past) byte_d = left_i;
        else if (sel_i.at) byte_d = ctl_i.din;
      end
      icb_pkg::COP_REMOVE: begin
        // the slot and everything above it take the next byte down
        if (sel_i.at || sel_i.past) byte_d = right_i;
      end
      default: begin
        byte_d = byte_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign q_o = byte_q;

endmodule

// ===== sv/icb_gather.sv =====
// registered and-or gather of the selected cell byte
`timescale 1ns / 1ps

module icb_gather #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                   clk_i,
  input  logic [CAPACITY-1:0][icb_pkg::CHAR_W-1:0] cells_i,
  input  logic [CAPACITY-1:0]                    sel_i,
  output logic [icb_pkg::CHAR_W-1:0]             byte_o
);

  localparam int unsigned NGRP = (CAPACITY + icb_pkg::GRP_SIZE - 1) / icb_pkg::GRP_SIZE;

  logic [NGRP-1:0][icb_pkg::CHAR_W-1:0] grp_d, grp_q;

  // first level: or within each group of cells
  always_comb begin
    grp_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      for (int k = 0; k < icb_pkg::GRP_SIZE; k++) begin
        if (g * icb_pkg::GRP_SIZE + k < CAPACITY) begin
          grp_d[g] = grp_d[g]
                   | (cells_i[g * icb_pkg::GRP_SIZE + k]
                      & {icb_pkg::CHAR_W{sel_i[g * icb_pkg::GRP_SIZE + k]}});
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  // second level: or across groups
  always_comb begin
    byte_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      byte_o = byte_o | grp_q[g];
    end
  end

endmodule

// ===== bench/indexed_char_buffer_tb.sv =====
// self-checking bench for the indexed char buffer: directed edits, a fill to capacity, random phases
`timescale 1ns / 1ps

module indexed_char_buffer_tb;

  localparam int CAP = 64;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  icb_pkg::icb_req_t req_i = '0;
  logic              done_o;
  icb_pkg::icb_rsp_t rsp_o;

  indexed_char_buffer #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always #10 clk_i = ~clk_i;

  // shadow copy of the stored bytes and the length
  logic [icb_pkg::CHAR_W-1:0] shadow_bytes [CAP];
  int                         shadow_len;

  // responses owed by the dut, oldest first
  icb_pkg::icb_rsp_t expected_rsp_q [$];

  int errors;
  int words_sent;
  int words_checked;
  int status_seen [4];
  int peak_len;
  int gap_pct;
  int target_len;

  // apply one edit to the shadow buffer and return the response it should give
  function automatic icb_pkg::icb_rsp_t apply_edit(icb_pkg::icb_req_t r);
    icb_pkg::icb_rsp_t rsp;
    int                pos;
    rsp.char_out = '0;
    rsp.status   = icb_pkg::ST_OK;
    case (r.func)
      icb_pkg::FN_APPEND: begin
        if (shadow_len >= CAP) begin
          rsp.status = icb_pkg::ST_FULL;
        end else begin
          shadow_bytes[shadow_len] = r.char_in;
          shadow_len++;
        end
      end
      icb_pkg::FN_INSERT: begin
        // full wins over a bad index
        if (shadow_len >= CAP) begin
          rsp.status = icb_pkg::ST_FULL;
        end else if (int'(r.index) > shadow_len) begin
          rsp.status = icb_pkg::ST_RANGE;
        end else begin
          for (pos = shadow_len; pos > int'(r.index); pos--)
            shadow_bytes[pos] = shadow_bytes[pos-1];
          shadow_bytes[r.index] = r.char_in;
          shadow_len++;
        end
      end
      icb_pkg::FN_SET: begin
        if (int'(r.index) >= shadow_len) rsp.status = icb_pkg::ST_RANGE;
        else shadow_bytes[r.index] = r.char_in;
      end
      icb_pkg::FN_GET: begin
        if (int'(r.index) >= shadow_len) rsp.status = icb_pkg::ST_RANGE;
        else rsp.char_out = shadow_bytes[r.index];
      end
      icb_pkg::FN_POP: begin
        if (shadow_len == 0) begin
          rsp.status = icb_pkg::ST_EMPTY;
        end else begin
          shadow_len--;
          rsp.char_out = shadow_bytes[shadow_len];
        end
      end
      icb_pkg::FN_REMOVE: begin
        if (int'(r.index) >= shadow_len) begin
          rsp.status = icb_pkg::ST_RANGE;
        end else begin
          rsp.char_out = shadow_bytes[r.index];
          for (pos = int'(r.index); pos + 1 < shadow_len; pos++)
            shadow_bytes[pos] = shadow_bytes[pos+1];
          shadow_len--;
        end
      end
      icb_pkg::FN_CLEAR: shadow_len = 0;
      default: ;  // unused code, nothing moves
    endcase
    rsp.length = shadow_len[icb_pkg::LEN_W-1:0];
    if (shadow_len > peak_len) peak_len = shadow_len;
    return rsp;
  endfunction

  // drive one word at the falling edge, hold it until taken, then log the owed response
  task automatic send_word(icb_pkg::icb_func_e fn, logic [icb_pkg::CHAR_W-1:0] ch,
                           logic [icb_pkg::INDEX_W-1:0] idx);
    icb_pkg::icb_req_t r;
    r.func    = fn;
    r.char_in = ch;
    r.index   = idx;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    // busy is sampled with the pre-edge value, same as the dut sees it
    do @(posedge clk_i); while (busy);
    expected_rsp_q.push_back(apply_edit(r));
    words_sent++;
  endtask

  // random idle cycles on the request side
  task automatic sender_gap();
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // stop sending and let every owed response come back
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // response checker: one strobe, one comparison against the oldest owed word
  always @(posedge clk_i) begin
    icb_pkg::icb_rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected response char_out=%0h length=%0d status=%0d",
                 $time, rsp_o.char_out, rsp_o.length, rsp_o.status);
        errors++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_o.char_out !== want.char_out) begin
          $display("%0t: char_out mismatch expected %0h actual %0h",
                   $time, want.char_out, rsp_o.char_out);
          errors++;
        end
        if (rsp_o.length !== want.length) begin
          $display("%0t: length mismatch expected %0d actual %0d",
                   $time, want.length, rsp_o.length);
          errors++;
        end
        if (rsp_o.status !== want.status) begin
          $display("%0t: status mismatch expected %0d actual %0d",
                   $time, want.status, rsp_o.status);
          errors++;
        end
        status_seen[want.status]++;
        words_checked++;
      end
    end
  end

  // errors on an empty buffer, the insert boundary, byte extremes, the unused code and clear
  task automatic test_directed();
    send_word(icb_pkg::FN_POP, 8'h00, 7'd0);       // pop on empty
    send_word(icb_pkg::FN_GET, 8'h00, 7'd0);       // get on empty is out of range
    send_word(icb_pkg::FN_SET, 8'hff, 7'd0);       // set on empty
    send_word(icb_pkg::FN_REMOVE, 8'h00, 7'd0);    // remove on empty
    send_word(icb_pkg::FN_INSERT, 8'h11, 7'd1);    // insert one past count
    send_word(icb_pkg::FN_INSERT, 8'hff, 7'd0);    // insert at count on empty is fine
    send_word(icb_pkg::FN_APPEND, 8'h00, 7'd127);  // index ignored by append
    send_word(icb_pkg::FN_APPEND, 8'h80, 7'd0);
    send_word(icb_pkg::FN_INSERT, 8'h5a, 7'd1);    // middle insert shifts up
    send_word(icb_pkg::FN_INSERT, 8'h01, 7'd4);    // insert exactly at count
    send_word(icb_pkg::FN_INSERT, 8'h02, 7'd6);    // beyond count
    send_word(icb_pkg::FN_GET, 8'h00, 7'd4);
    send_word(icb_pkg::FN_GET, 8'h00, 7'd5);       // index equal to count
    send_word(icb_pkg::FN_GET, 8'h00, 7'd127);
    send_word(icb_pkg::FN_SET, 8'h7f, 7'd2);
    send_word(icb_pkg::FN_GET, 8'h00, 7'd2);
    send_word(icb_pkg::FN_NOP, 8'hff, 7'd127);     // unused code leaves everything alone
    send_word(icb_pkg::FN_REMOVE, 8'h00, 7'd1);    // remove in the middle shifts down
    send_word(icb_pkg::FN_REMOVE, 8'h00, 7'd3);    // remove the last byte
    send_word(icb_pkg::FN_REMOVE, 8'h00, 7'd3);    // now past the end
    send_word(icb_pkg::FN_POP, 8'h00, 7'd0);
    send_word(icb_pkg::FN_CLEAR, 8'hff, 7'd127);
    send_word(icb_pkg::FN_GET, 8'h00, 7'd0);       // cleared bytes are no longer readable
    send_word(icb_pkg::FN_POP, 8'h00, 7'd0);
    drain();
  endtask

  // fill to capacity, then hit every edge of a full buffer
  task automatic test_full();
    int k;
    for (k = 0; k < CAP; k++) send_word(icb_pkg::FN_APPEND, 8'($urandom_range(255)), 7'd0);
    send_word(icb_pkg::FN_APPEND, 8'h33, 7'd0);     // append when full
    send_word(icb_pkg::FN_INSERT, 8'h44, 7'd0);     // insert when full
    send_word(icb_pkg::FN_INSERT, 8'h44, 7'd127);   // full is reported before the bad index
    send_word(icb_pkg::FN_GET, 8'h00, 7'd63);
    send_word(icb_pkg::FN_GET, 8'h00, 7'd64);
    send_word(icb_pkg::FN_SET, 8'hff, 7'd63);
    send_word(icb_pkg::FN_SET, 8'hff, 7'd64);
    send_word(icb_pkg::FN_REMOVE, 8'h00, 7'd0);     // full-length shift down
    send_word(icb_pkg::FN_INSERT, 8'hc3, 7'd0);     // full-length shift up back to capacity
    send_word(icb_pkg::FN_REMOVE, 8'h00, 7'd63);
    send_word(icb_pkg::FN_INSERT, 8'h3c, 7'd63);
    send_word(icb_pkg::FN_POP, 8'h00, 7'd0);
    send_word(icb_pkg::FN_APPEND, 8'h96, 7'd0);
    send_word(icb_pkg::FN_CLEAR, 8'h00, 7'd0);
    drain();
  endtask

  // pick an edit that steers the length toward the current target
  function automatic icb_pkg::icb_func_e pick_func();
    int r;
    r = $urandom_range(99);
    if (r < 18) return icb_pkg::icb_func_e'($urandom_range(7));
    if (r < 45) return $urandom_range(1) ? icb_pkg::FN_SET : icb_pkg::FN_GET;
    if (shadow_len < target_len)
      return $urandom_range(1) ? icb_pkg::FN_APPEND : icb_pkg::FN_INSERT;
    if (shadow_len > target_len)
      return $urandom_range(1) ? icb_pkg::FN_POP : icb_pkg::FN_REMOVE;
    return $urandom_range(1) ? icb_pkg::FN_INSERT : icb_pkg::FN_REMOVE;
  endfunction

  // mostly in-range positions, including the one just past the end, plus wide noise
  function automatic logic [icb_pkg::INDEX_W-1:0] pick_index();
    if ($urandom_range(99) < 15 || shadow_len == 0)
      return icb_pkg::INDEX_W'($urandom_range(127));
    return icb_pkg::INDEX_W'($urandom_range(shadow_len));
  endfunction

  // random edits in phases of different sender idling, pausing for all responses between
  task automatic test_random(int n_words);
    int phase_gap [5] = '{0, 62, 7, 62, 0};
    int p;
    int k;
    for (p = 0; p < 5; p++) begin
      gap_pct = phase_gap[p];
      for (k = 0; k < n_words / 5; k++) begin
        // new length target now and then, extremes favored
        if (k % 40 == 0) begin
          case ($urandom_range(3))
            0: target_len = 0;
            1: target_len = CAP;
            default: target_len = $urandom_range(CAP);
          endcase
        end
        sender_gap();
        send_word(pick_func(), 8'($urandom_range(255)), pick_index());
      end
      drain();
    end
    gap_pct = 0;
  endtask

  initial begin
    errors        = 0;
    words_sent    = 0;
    words_checked = 0;
    peak_len      = 0;
    gap_pct       = 0;
    target_len    = 0;
    shadow_len    = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_full();
    test_random(750);

    drain();
    // result strobe trails acceptance through v1_q and done_q, keep waiting for strays
    repeat (8) @(posedge clk_i);

    $display("words %0d, responses checked %0d, peak length %0d", words_sent, words_checked,
             peak_len);
    $display("status counts: ok %0d, range %0d, empty %0d, full %0d",
             status_seen[icb_pkg::ST_OK], status_seen[icb_pkg::ST_RANGE],
             status_seen[icb_pkg::ST_EMPTY], status_seen[icb_pkg::ST_FULL]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
